### hdl/fpfc_pkg.sv
package fpfc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int REG_WIDTH   = 31;
    localparam int NUM_REGS    = 8;
    localparam int IDX_WIDTH   = 3;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    localparam value_t VMAX = value_t'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    localparam value_t VMIN = value_t'({1'b1, {(VALUE_WIDTH-1){1'b0}}});

    // 0.7 s threshold and the 30 clamp limit
    localparam logic [REG_WIDTH-1:0] TIME_THRESH =
        REG_WIDTH'((64'd7 << FRAC_BITS) / 64'd10);
    localparam value_t FRIC_LIMIT = value_t'(64'd30 << FRAC_BITS);

    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_STIFFNESS = 3'd3,
        REG_MASS_M    = 3'd4,
        REG_MASS_L    = 3'd5,
        REG_PERIOD    = 3'd6,
        REG_INV_PER   = 3'd7
    } reg_idx_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_SF, S_MODEL, S_F1, S_F2, S_ERR, S_DERR, S_INT,
        S_P, S_D, S_I, S_OUT
    } bstate_t;

    // One classified tick handed from the front to the back
    typedef struct packed {
        value_t ref_force;
        value_t tau;
        value_t torque;
        value_t acc_m;
        value_t x_e;
        value_t acc_l;
        logic   latch;   // this tick sets the start latch
    } tick_t;

    function automatic value_t sat_add(input value_t a, input value_t b);
        logic signed [VALUE_WIDTH:0] s;
        begin
            s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
            if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
                sat_add = s[VALUE_WIDTH] ? VMIN : VMAX;
            else
                sat_add = s[VALUE_WIDTH-1:0];
        end
    endfunction

    function automatic value_t sat_sub(input value_t a, input value_t b);
        logic signed [VALUE_WIDTH:0] s;
        begin
            s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
            if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
                sat_sub = s[VALUE_WIDTH] ? VMIN : VMAX;
            else
                sat_sub = s[VALUE_WIDTH-1:0];
        end
    endfunction

endpackage

### hdl/fpfc_front.sv
// Front end: input beat capture, start-latch decision, small FIFO.
module fpfc_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  fpfc_pkg::value_t                       ref_force,
    input  fpfc_pkg::value_t                       spring_force,
    input  fpfc_pkg::value_t                       motor_torque,
    input  fpfc_pkg::value_t                       motor_accel,
    input  fpfc_pkg::value_t                       load_position,
    input  fpfc_pkg::value_t                       load_accel,
    input  logic [fpfc_pkg::REG_WIDTH-1:0]         now_time,
    output logic                                   q_valid,
    input  logic                                   q_ready,
    output fpfc_pkg::tick_t                        q_data
);

    fpfc_pkg::tick_t fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       started_reg;
    logic       push, pop;
    fpfc_pkg::tick_t t;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        t.ref_force = ref_force;
        t.tau       = spring_force;
        t.torque    = motor_torque;
        t.acc_m     = motor_accel;
        t.x_e       = load_position;
        t.acc_l     = load_accel;
        t.latch     = !started_reg && (now_time > fpfc_pkg::TIME_THRESH);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (push && t.latch)
                started_reg <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push) else $error("fifo overflow");
    a_latch_once: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> !t.latch) else $error("latch set twice");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("bad fifo count");
`endif

endmodule

### hdl/fpfc_back.sv
// Back end: sequenced shared multiplier and divider, state update, result register.
module fpfc_back (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           q_valid,
    output logic                                           q_ready,
    input  fpfc_pkg::tick_t                                q_data,
    input  logic [fpfc_pkg::NUM_REGS-1:0][fpfc_pkg::REG_WIDTH-1:0] regs,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output fpfc_pkg::value_t                               drive,
    output fpfc_pkg::value_t                               friction_motor,
    output fpfc_pkg::value_t                               friction_load,
    output fpfc_pkg::value_t                               model_spring_force,
    output fpfc_pkg::value_t                               start_force
);
    localparam int VW = fpfc_pkg::VALUE_WIDTH;
    localparam int FB = fpfc_pkg::FRAC_BITS;
    localparam int QW = VW + FB;          // dividend width
    localparam int CW = $clog2(QW + 1);

    fpfc_pkg::bstate_t state_reg, state_next;
    fpfc_pkg::tick_t tk_reg;
    fpfc_pkg::value_t start_pos_reg, start_sf_reg, past_err_reg, integ_reg;
    fpfc_pkg::value_t model_reg, f1_reg, f2_reg, err_reg, derr_reg, pid_reg;
    fpfc_pkg::value_t ratio_reg;
    fpfc_pkg::value_t drive_reg, f1o_reg, f2o_reg, modelo_reg, sfo_reg;
    logic        started_reg;
    logic        out_valid_reg;
    logic [QW-1:0]  quo_reg;
    logic [VW-1:0]  rem_reg;
    logic [CW-1:0]  cnt_reg;

    // shared multiplier, one per cycle
    fpfc_pkg::value_t ma, mb, mres;
    logic signed [2*VW-1:0] prod;
    logic signed [2*VW-1:0] sh;

    always_comb
    begin
        prod = ma * mb;
        sh   = prod >>> FB;   // arithmetic shift = floor
        if (sh > (2*VW)'(fpfc_pkg::VMAX))
            mres = fpfc_pkg::VMAX;
        else if (sh < (2*VW)'(fpfc_pkg::VMIN))
            mres = fpfc_pkg::VMIN;
        else
            mres = sh[VW-1:0];
    end

    fpfc_pkg::value_t kval, m1, m2, half, c30n, tot;
    logic [VW:0] rem_try;
    assign kval = {1'b0, regs[fpfc_pkg::REG_STIFFNESS]};
    assign m1   = {1'b0, regs[fpfc_pkg::REG_MASS_M]};
    assign m2   = {1'b0, regs[fpfc_pkg::REG_MASS_L]};
    assign half = tk_reg.tau >>> 1;
    assign c30n = -fpfc_pkg::FRIC_LIMIT;
    assign rem_try = {rem_reg, quo_reg[QW-1]} - {1'b0, m1};
    assign tot  = fpfc_pkg::sat_sub(f1_reg, f2_reg);

    assign q_ready   = (state_reg == fpfc_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive = drive_reg;
    assign friction_motor = f1o_reg;
    assign friction_load = f2o_reg;
    assign model_spring_force = modelo_reg;
    assign start_force = sfo_reg;

    always_comb
    begin
        state_next = state_reg;
        ma = '0;
        mb = '0;
        unique case (state_reg)
            fpfc_pkg::S_IDLE:
                if (q_valid)
                    state_next = q_data.latch ? fpfc_pkg::S_DIV : fpfc_pkg::S_MODEL;
            fpfc_pkg::S_DIV:
                if (m1 == '0 || cnt_reg == '0)
                    state_next = fpfc_pkg::S_SF;
            fpfc_pkg::S_SF:
            begin
                ma = half;
                mb = ratio_reg;
                state_next = fpfc_pkg::S_MODEL;
            end
            fpfc_pkg::S_MODEL:
            begin
                ma = kval;
                mb = fpfc_pkg::sat_sub(tk_reg.x_e, start_pos_reg);
                state_next = fpfc_pkg::S_F1;
            end
            fpfc_pkg::S_F1:
            begin
                ma = m1;
                mb = tk_reg.acc_m;
                state_next = fpfc_pkg::S_F2;
            end
            fpfc_pkg::S_F2:
            begin
                ma = m2;
                mb = tk_reg.acc_l;
                state_next = fpfc_pkg::S_ERR;
            end
            fpfc_pkg::S_ERR:
                state_next = fpfc_pkg::S_DERR;
            fpfc_pkg::S_DERR:
            begin
                ma = fpfc_pkg::sat_sub(err_reg, past_err_reg);
                mb = {1'b0, regs[fpfc_pkg::REG_INV_PER]};
                state_next = fpfc_pkg::S_INT;
            end
            fpfc_pkg::S_INT:
            begin
                ma = err_reg;
                mb = {1'b0, regs[fpfc_pkg::REG_PERIOD]};
                state_next = fpfc_pkg::S_P;
            end
            fpfc_pkg::S_P:
            begin
                ma = {1'b0, regs[fpfc_pkg::REG_GAIN_P]};
                mb = err_reg;
                state_next = fpfc_pkg::S_D;
            end
            fpfc_pkg::S_D:
            begin
                ma = {1'b0, regs[fpfc_pkg::REG_GAIN_D]};
                mb = derr_reg;
                state_next = fpfc_pkg::S_I;
            end
            fpfc_pkg::S_I:
            begin
                ma = {1'b0, regs[fpfc_pkg::REG_GAIN_I]};
                mb = integ_reg;
                state_next = fpfc_pkg::S_OUT;
            end
            fpfc_pkg::S_OUT:
                if (!out_valid_reg || out_ready)
                    state_next = fpfc_pkg::S_IDLE;
            default: state_next = fpfc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpfc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            start_pos_reg <= '0;
            start_sf_reg  <= '0;
            past_err_reg  <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fpfc_pkg::S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                fpfc_pkg::S_DIV:
                    if (m1 != '0 && cnt_reg != '0)
                    begin
                        // restoring divide, one quotient bit per cycle
                        if (!rem_try[VW])
                        begin
                            rem_reg <= rem_try[VW-1:0];
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[VW-2:0], quo_reg[QW-1]};
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else
                    begin
                        if (m1 == '0 || quo_reg[QW-1:VW-1] != '0)
                            ratio_reg <= fpfc_pkg::VMAX;
                        else
                            ratio_reg <= quo_reg[VW-1:0];
                    end
                fpfc_pkg::S_SF:
                begin
                    start_pos_reg <= tk_reg.x_e;
                    start_sf_reg  <= fpfc_pkg::sat_add(half, mres);
                end
                fpfc_pkg::S_MODEL: model_reg <= fpfc_pkg::sat_add(mres, start_sf_reg);
                fpfc_pkg::S_F1: f1_reg <= fpfc_pkg::sat_sub(
                          fpfc_pkg::sat_sub(tk_reg.torque, mres), tk_reg.tau);
                fpfc_pkg::S_F2: f2_reg <= fpfc_pkg::sat_sub(
                          fpfc_pkg::sat_sub(tk_reg.tau, mres), model_reg);
                fpfc_pkg::S_ERR:
                begin
                    err_reg <= fpfc_pkg::sat_sub(tk_reg.ref_force, tk_reg.tau);
                    if (!started_reg)
                    begin
                        f1_reg <= '0;
                        f2_reg <= '0;
                    end
                end
                fpfc_pkg::S_DERR: derr_reg <= mres;
                fpfc_pkg::S_INT:
                begin
                    integ_reg    <= fpfc_pkg::sat_add(integ_reg, mres);
                    past_err_reg <= err_reg;
                end
                fpfc_pkg::S_P: pid_reg <= fpfc_pkg::sat_add(tk_reg.ref_force, mres);
                fpfc_pkg::S_D: pid_reg <= fpfc_pkg::sat_add(pid_reg, mres);
                fpfc_pkg::S_I: pid_reg <= fpfc_pkg::sat_add(pid_reg, mres);
                fpfc_pkg::S_OUT:
                    if (!out_valid_reg || out_ready)
                    begin
                        if (tot > fpfc_pkg::FRIC_LIMIT)
                            drive_reg <= fpfc_pkg::sat_add(pid_reg, fpfc_pkg::FRIC_LIMIT);
                        else if (tot < c30n)
                            drive_reg <= fpfc_pkg::sat_add(pid_reg, c30n);
                        else
                            drive_reg <= fpfc_pkg::sat_add(pid_reg, tot);
                        f1o_reg    <= f1_reg;
                        f2o_reg    <= f2_reg;
                        modelo_reg <= model_reg;
                        sfo_reg    <= start_sf_reg;
                    end
                default: ;
            endcase
            if (state_reg == fpfc_pkg::S_IDLE && q_valid)
            begin
                tk_reg  <= q_data;
                quo_reg <= {m2[VW-2:0], {FB{1'b0}}, 1'b0} >> 1;
                rem_reg <= '0;
                cnt_reg <= CW'(QW);
            end
        end
    end

    // start latch as seen by the back, set once the start force is captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            started_reg <= 1'b0;
        else if (state_reg == fpfc_pkg::S_SF)
            started_reg <= 1'b1;
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg) else $error("result dropped");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == fpfc_pkg::S_IDLE) else $error("ready outside idle");
    a_sf_latch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpfc_pkg::S_SF |=> started_reg) else $error("latch not recorded");
`endif

endmodule

### hdl/fpfc_cfg.sv
// Configuration register file.
module fpfc_cfg (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           cfg_valid,
    output logic                                           cfg_ready,
    input  logic [fpfc_pkg::IDX_WIDTH-1:0]                 cfg_index,
    input  logic [fpfc_pkg::REG_WIDTH-1:0]                 cfg_data,
    output logic [fpfc_pkg::NUM_REGS-1:0][fpfc_pkg::REG_WIDTH-1:0] regs
);
    logic [fpfc_pkg::NUM_REGS-1:0][fpfc_pkg::REG_WIDTH-1:0] regs_reg;

    assign cfg_ready = 1'b1;
    assign regs = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[fpfc_pkg::REG_GAIN_P]    <= '0;
            regs_reg[fpfc_pkg::REG_GAIN_I]    <= '0;
            regs_reg[fpfc_pkg::REG_GAIN_D]    <= '0;
            regs_reg[fpfc_pkg::REG_STIFFNESS] <= '0;
            regs_reg[fpfc_pkg::REG_MASS_M]    <= fpfc_pkg::REG_WIDTH'(65536);
            regs_reg[fpfc_pkg::REG_MASS_L]    <= fpfc_pkg::REG_WIDTH'(65536);
            regs_reg[fpfc_pkg::REG_PERIOD]    <= fpfc_pkg::REG_WIDTH'(66);
            regs_reg[fpfc_pkg::REG_INV_PER]   <= fpfc_pkg::REG_WIDTH'(65536000);
        end
        else if (cfg_valid)
            regs_reg[cfg_index] <= cfg_data;
    end
endmodule

### hdl/force_pid_friction_compensation.sv
// Force PID loop with friction compensation, Q16.16 throughout with saturating
// arithmetic. The front latches each input beat, decides whether this tick
// sets the start latch (time above 0.7 s, once), and queues it in a two-entry
// FIFO. The back runs the tick through one shared 32x32 multiplier, one
// product per cycle: an ordinary tick passes one idle handoff state and ten
// working states, and its result is registered in the last of them once the
// output register is free. The latch tick adds the bit-serial mass-ratio
// divider and the start-force product before the working states. The result
// sits in an output register so the next tick can start while it waits to be
// taken. Configuration writes are always ready and must only be issued while
// idle.
module force_pid_friction_compensation (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fpfc_pkg::IDX_WIDTH-1:0]     cfg_index,
    input  logic [fpfc_pkg::REG_WIDTH-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  fpfc_pkg::value_t                   ref_force,
    input  fpfc_pkg::value_t                   spring_force,
    input  fpfc_pkg::value_t                   motor_torque,
    input  fpfc_pkg::value_t                   motor_accel,
    input  fpfc_pkg::value_t                   load_position,
    input  fpfc_pkg::value_t                   load_accel,
    input  logic [fpfc_pkg::REG_WIDTH-1:0]     now_time,
    output logic                               out_valid,
    input  logic                               out_ready,
    output fpfc_pkg::value_t                   drive,
    output fpfc_pkg::value_t                   friction_motor,
    output fpfc_pkg::value_t                   friction_load,
    output fpfc_pkg::value_t                   model_spring_force,
    output fpfc_pkg::value_t                   start_force
);
    logic [fpfc_pkg::NUM_REGS-1:0][fpfc_pkg::REG_WIDTH-1:0] regs;
    logic            q_valid, q_ready;
    fpfc_pkg::tick_t q_data;

    fpfc_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .regs(regs)
    );

    fpfc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .ref_force(ref_force), .spring_force(spring_force),
        .motor_torque(motor_torque), .motor_accel(motor_accel),
        .load_position(load_position), .load_accel(load_accel),
        .now_time(now_time), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    fpfc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .regs(regs), .out_valid(out_valid), .out_ready(out_ready),
        .drive(drive), .friction_motor(friction_motor), .friction_load(friction_load),
        .model_spring_force(model_spring_force), .start_force(start_force)
    );
endmodule

### bench/tb_force_pid_friction_compensation.sv
module tb_force_pid_friction_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    // Signed 64-bit working values; every value is held in the 32-bit range.
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_TICKS = 700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [fpfc_pkg::IDX_WIDTH-1:0] cfg_index = '0;
    logic [fpfc_pkg::REG_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    fpfc_pkg::value_t ref_force = '0, spring_force = '0, motor_torque = '0;
    fpfc_pkg::value_t motor_accel = '0, load_position = '0, load_accel = '0;
    logic [fpfc_pkg::REG_WIDTH-1:0] now_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    fpfc_pkg::value_t drive, friction_motor, friction_load, model_spring_force;
    fpfc_pkg::value_t start_force;

    force_pid_friction_compensation dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct packed {
        fpfc_pkg::value_t drive;
        fpfc_pkg::value_t f_motor;
        fpfc_pkg::value_t f_load;
        fpfc_pkg::value_t model;
        fpfc_pkg::value_t start;
    } control_out_t;

    typedef struct {
        fpfc_pkg::value_t ref_force;
        fpfc_pkg::value_t tau;
        fpfc_pkg::value_t torque;
        fpfc_pkg::value_t acc_m;
        fpfc_pkg::value_t x_e;
        fpfc_pkg::value_t acc_l;
        logic [fpfc_pkg::REG_WIDTH-1:0] now;
        bit has_exp;        // expected row typed in
        control_out_t exp_out;
    } tick_row_t;

    // Predictor state: registers and loop state.
    longint gains[fpfc_pkg::NUM_REGS];
    bit latched;
    longint x_start, f_start, err_prev, err_sum;

    control_out_t pending_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit quiet_stretch = 1'b0;

    function automatic longint qclamp(longint v);
        return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    // Operands stay within 32 bits, so the 64-bit sum/difference never wraps.
    function automatic longint qadd(longint a, longint b);
        return qclamp(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return qclamp(a - b);
    endfunction

    // Full product, arithmetic shift floors toward minus infinity.
    function automatic longint qmul(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        p = p >>> fpfc_pkg::FRAC_BITS;
        if (p > 128'(QMAX)) return QMAX;
        if (p < 128'(QMIN)) return QMIN;
        return longint'(p);
    endfunction

    task automatic reset_control_model();
        gains = '{0, 0, 0, 0, 65536, 65536, 66, 65536000};
        latched = 1'b0;
        x_start = 0; f_start = 0; err_prev = 0; err_sum = 0;
    endtask

    function automatic control_out_t compute_control(tick_row_t t);
        control_out_t r;
        longint tau, model, f1, f2, e, de, pid, fr, ratio, half, lim;
        tau = longint'(t.tau);
        lim = longint'(fpfc_pkg::FRIC_LIMIT);
        f1 = 0; f2 = 0;
        if (!latched && t.now > fpfc_pkg::TIME_THRESH)
        begin
            // zero motor mass saturates the ratio
            if (gains[fpfc_pkg::REG_MASS_M] == 0)
                ratio = QMAX;
            else
                ratio = qclamp((gains[fpfc_pkg::REG_MASS_L] << fpfc_pkg::FRAC_BITS)
                               / gains[fpfc_pkg::REG_MASS_M]);
            half = tau >>> 1;
            x_start = longint'(t.x_e);
            f_start = qadd(half, qmul(half, ratio));
            latched = 1'b1;
        end
        model = qadd(qmul(gains[fpfc_pkg::REG_STIFFNESS], qsub(longint'(t.x_e), x_start)),
                     f_start);
        if (latched)
        begin
            f1 = qsub(qsub(longint'(t.torque),
                           qmul(gains[fpfc_pkg::REG_MASS_M], longint'(t.acc_m))), tau);
            f2 = qsub(qsub(tau, qmul(gains[fpfc_pkg::REG_MASS_L], longint'(t.acc_l))),
                      model);
        end
        e = qsub(longint'(t.ref_force), tau);
        de = qmul(qsub(e, err_prev), gains[fpfc_pkg::REG_INV_PER]);
        err_sum = qadd(err_sum, qmul(e, gains[fpfc_pkg::REG_PERIOD]));
        err_prev = e;
        pid = qadd(longint'(t.ref_force), qmul(gains[fpfc_pkg::REG_GAIN_P], e));
        pid = qadd(pid, qmul(gains[fpfc_pkg::REG_GAIN_D], de));
        pid = qadd(pid, qmul(gains[fpfc_pkg::REG_GAIN_I], err_sum));
        fr = qsub(f1, f2);
        if (fr > lim) fr = lim;
        else if (fr < -lim) fr = -lim;
        r.drive = fpfc_pkg::value_t'(qadd(pid, fr));
        r.f_motor = fpfc_pkg::value_t'(f1);
        r.f_load = fpfc_pkg::value_t'(f2);
        r.model = fpfc_pkg::value_t'(model);
        r.start = fpfc_pkg::value_t'(f_start);
        return r;
    endfunction

    function automatic bit idle_now();
        return !quiet_stretch && ($urandom_range(99) < 12);
    endfunction

    // Output side: random backpressure, compare each beat with oldest prediction.
    always @(negedge clk)
        if (rst_n) out_ready <= !idle_now();

    always @(posedge clk)
    begin
        control_out_t e;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat, drive=%h", drive);
                end
                else
                begin
                    e = pending_q.pop_front();
                    if (e.drive !== drive || e.f_motor !== friction_motor
                        || e.f_load !== friction_load || e.model !== model_spring_force
                        || e.start !== start_force)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h %h %h %h %h got %h %h %h %h %h",
                                e.drive, e.f_motor, e.f_load, e.model, e.start, drive,
                                friction_motor, friction_load, model_spring_force,
                                start_force);
                    end
                end
            end
        end
    end

    always @(posedge clk)
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_force_pid_friction_compensation: FAIL");
            $finish;
        end

    task automatic write_reg(fpfc_pkg::reg_idx_t idx, logic [fpfc_pkg::REG_WIDTH-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        gains[idx] = longint'(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drive one tick beat; the prediction is queued at acceptance. Valid is
    // left high so the next beat can follow without a gap.
    task automatic send_tick(tick_row_t t);
        control_out_t p;
        @(negedge clk);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ref_force <= t.ref_force; spring_force <= t.tau; motor_torque <= t.torque;
        motor_accel <= t.acc_m; load_position <= t.x_e; load_accel <= t.acc_l;
        now_time <= t.now;
        do @(posedge clk); while (!in_ready);
        p = compute_control(t);
        if (t.has_exp && p !== t.exp_out)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("typed row mismatch exp %h got %h", t.exp_out, p);
        end
        pending_q.insert(pending_q.size(), p);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic fpfc_pkg::value_t rand_value();
        case ($urandom_range(5))
            0: return fpfc_pkg::VMAX;
            1: return fpfc_pkg::VMIN;
            2: return fpfc_pkg::value_t'($urandom_range(2 * 65536))
                      - fpfc_pkg::value_t'(65536);
            3: return fpfc_pkg::value_t'($urandom_range(100 * 65536))
                      - fpfc_pkg::value_t'(50 * 65536);
            default: return fpfc_pkg::value_t'($urandom);
        endcase
    endfunction

    function automatic logic [fpfc_pkg::REG_WIDTH-1:0] rand_gain();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return fpfc_pkg::REG_WIDTH'($urandom_range(4 * 65536));
            default: return fpfc_pkg::REG_WIDTH'($urandom);
        endcase
    endfunction

    function automatic tick_row_t rand_tick(bit early);
        tick_row_t t;
        t.ref_force = rand_value(); t.tau = rand_value(); t.torque = rand_value();
        t.acc_m = rand_value(); t.x_e = rand_value(); t.acc_l = rand_value();
        t.now = early ? fpfc_pkg::REG_WIDTH'($urandom_range(fpfc_pkg::TIME_THRESH))
                      : ($urandom_range(3) == 0
                         ? fpfc_pkg::REG_WIDTH'($urandom)
                         : fpfc_pkg::TIME_THRESH
                           + fpfc_pkg::REG_WIDTH'($urandom_range(65536)));
        t.has_exp = 1'b0;
        t.exp_out = '0;
        return t;
    endfunction

    tick_row_t directed[$];

    task automatic add_row(tick_row_t r);
        directed.insert(directed.size(), r);
    endtask

    initial
    begin
        control_out_t z;
        reset_control_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. With reset gains, a zero tick gives all-zero results.
        z = '0;
        add_row('{'0, '0, '0, '0, '0, '0, '0, 1'b1, z});
        // reference passes straight through with zero gains before latch
        z.drive = fpfc_pkg::VMAX;
        add_row('{fpfc_pkg::VMAX, '0, '0, '0, '0, '0, '0, 1'b1, z});
        add_row('{fpfc_pkg::VMIN, fpfc_pkg::VMAX, fpfc_pkg::VMIN, fpfc_pkg::VMAX,
                  fpfc_pkg::VMIN, fpfc_pkg::VMAX, '0, 1'b0, z});
        // at threshold: no latch yet
        add_row('{fpfc_pkg::value_t'(65536), fpfc_pkg::value_t'(-65536), '0, '0,
                  fpfc_pkg::value_t'(1000), '0, fpfc_pkg::TIME_THRESH, 1'b0, z});
        // just above threshold: latch tick, odd negative tau checks floor halving
        add_row('{fpfc_pkg::value_t'(3 * 65536), fpfc_pkg::value_t'(-3),
                  fpfc_pkg::value_t'(5 * 65536), fpfc_pkg::value_t'(65536),
                  fpfc_pkg::value_t'(1234), fpfc_pkg::value_t'(-65536),
                  fpfc_pkg::TIME_THRESH + 1'b1, 1'b0, z});
        add_row('{fpfc_pkg::VMAX, fpfc_pkg::VMIN, fpfc_pkg::VMAX, fpfc_pkg::VMIN,
                  fpfc_pkg::VMAX, fpfc_pkg::VMIN, '1, 1'b0, z});
        add_row('{fpfc_pkg::VMIN, fpfc_pkg::VMAX, fpfc_pkg::VMIN, fpfc_pkg::VMAX,
                  fpfc_pkg::VMIN, fpfc_pkg::VMAX, '1, 1'b0, z});
        add_row('{'0, fpfc_pkg::value_t'(100 * 65536), fpfc_pkg::value_t'(-100 * 65536),
                  '0, '0, '0, '1, 1'b0, z});
        foreach (directed[i]) send_tick(directed[i]);
        wait_drained();

        // Several register settings, extremes included. The latch sets only
        // once per reset, so these phases exercise the latched path.
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                    for (int r = 0; r < fpfc_pkg::NUM_REGS; r++)
                        write_reg(fpfc_pkg::reg_idx_t'(r), '1);
                1:
                begin
                    for (int r = 0; r < fpfc_pkg::NUM_REGS; r++)
                        write_reg(fpfc_pkg::reg_idx_t'(r), '0);
                    write_reg(fpfc_pkg::REG_INV_PER, fpfc_pkg::REG_WIDTH'(1));
                    write_reg(fpfc_pkg::REG_PERIOD, fpfc_pkg::REG_WIDTH'(1));
                end
                default:
                    for (int r = 0; r < fpfc_pkg::NUM_REGS; r++)
                        write_reg(fpfc_pkg::reg_idx_t'(r), rand_gain());
            endcase
            quiet_stretch = (phase == 3);
            for (int n = 0; n < RANDOM_TICKS / 7; n++)
                send_tick(rand_tick(1'b0));
            wait_drained();
        end
        quiet_stretch = 1'b0;

        if (mismatches == 0 && pending_q.size() == 0)
            $display("tb_force_pid_friction_compensation: PASS");
        else
            $display("tb_force_pid_friction_compensation: FAIL");
        $finish;
    end

endmodule
